// ===== hw/rtl/point_zbuffer_projector_top_defines.svh =====
// assertion macros for the point z-buffer projector checker
`ifndef POINT_ZBUFFER_PROJECTOR_TOP_DEFINES_SVH
`define POINT_ZBUFFER_PROJECTOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PZB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pzb same-cycle check failed");

// next-cycle implication, disabled during reset
`define PZB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pzb next-cycle check failed");

`endif

// ===== hw/rtl/pzb_pkg.sv =====
// shared types and constants for the point z-buffer projector
package pzb_pkg;

  localparam int MAX_SIDE        = 256;
  localparam int COORD_FRAC_BITS = 13;
  localparam int COORD_W         = 16;
  localparam int SIDE_W          = 9;
  localparam int ASPECT_W        = 14;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 14;
  localparam int SUM_W           = COORD_W + 2;
  localparam int PROD_W          = SUM_W + SIDE_W + 1;
  localparam int PIX_W           = PROD_W - COORD_FRAC_BITS - 1;
  localparam int IDX_W           = 2 * SIDE_W;

  localparam logic [SIDE_W-1:0]   WIDTH_RST  = SIDE_W'(256);
  localparam logic [SIDE_W-1:0]   HEIGHT_RST = SIDE_W'(256);
  localparam logic [ASPECT_W-1:0] ASPECT_RST = ASPECT_W'(8192);
  localparam logic [ASPECT_W-1:0] COORD_ONE  = ASPECT_W'(1 << COORD_FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_ASPECT_OFFSET = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_PROJECT = 1'b0,
    CMD_CLEAR   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_BUSY
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              inb;
    logic [SIDE_W-1:0] col;
    logic [SIDE_W-1:0] row;
  } pix_req_t;

  typedef struct packed {
    logic sweep_last;
    logic done;
  } store_stat_t;

endpackage

// ===== hw/rtl/pzb_project.sv =====
// vertex to pixel mapping pipeline: offset, scale, round, bounds, store index
module pzb_project #(
  parameter int DEPTH_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic signed [pzb_pkg::COORD_W-1:0]   vertex_x,
  input  logic signed [pzb_pkg::COORD_W-1:0]   vertex_y,
  input  logic signed [DEPTH_BITS-1:0]         vertex_depth,
  input  logic [pzb_pkg::SIDE_W-1:0]           cfg_width,
  input  logic [pzb_pkg::SIDE_W-1:0]           cfg_height,
  input  logic [pzb_pkg::ASPECT_W-1:0]         cfg_aspect,
  output pzb_pkg::pix_req_t                    req,
  output logic [pzb_pkg::IDX_W-1:0]            req_addr,
  output logic signed [DEPTH_BITS-1:0]         req_depth
);
  import pzb_pkg::*;

  function automatic logic [PIX_W:0] round_pix(input logic signed [PROD_W-1:0] num);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] biased;
    logic [PIX_W-1:0]  r;
    mag    = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
    biased = mag + PROD_W'(1 << COORD_FRAC_BITS);
    r      = biased[PROD_W-1:COORD_FRAC_BITS+1];
    return {num[PROD_W-1] && (r != '0), r};
  endfunction

  logic [SIDE_W-1:0]        w_c, h_c, len_c;
  logic [ASPECT_W-1:0]      off_x, off_y;
  logic signed [SUM_W-1:0]  sum_x_nxt, sum_y_nxt;

  logic                     s1_valid_r;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r;
  logic [SIDE_W-1:0]        len_r, w1_r, h1_r;
  logic signed [DEPTH_BITS-1:0] depth1_r;

  logic                     s2_valid_r;
  logic signed [PROD_W-1:0] prod_x_nxt, prod_y_nxt;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r;
  logic [SIDE_W-1:0]        w2_r, h2_r;
  logic signed [DEPTH_BITS-1:0] depth2_r;

  logic [PIX_W:0]           rnd_x, rnd_y;
  logic                     inb_nxt;
  logic                     s3_valid_r, inb3_r;
  logic [SIDE_W-1:0]        col3_r, row3_r, h3_r;
  logic signed [DEPTH_BITS-1:0] depth3_r;

  logic [IDX_W-1:0]         idx_nxt;
  logic                     s4_valid_r, inb4_r;
  logic [SIDE_W-1:0]        col4_r, row4_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [DEPTH_BITS-1:0] depth4_r;

  always_comb begin
    w_c = cfg_width;
    if (cfg_width == '0) begin
      w_c = SIDE_W'(1);
    end else if (32'(cfg_width) > MAX_SIDE) begin
      w_c = SIDE_W'(MAX_SIDE);
    end
    h_c = cfg_height;
    if (cfg_height == '0) begin
      h_c = SIDE_W'(1);
    end else if (32'(cfg_height) > MAX_SIDE) begin
      h_c = SIDE_W'(MAX_SIDE);
    end
    len_c     = (h_c >= w_c) ? h_c : w_c;
    off_x     = (h_c >= w_c) ? cfg_aspect : COORD_ONE;
    off_y     = (h_c >= w_c) ? COORD_ONE : cfg_aspect;
    sum_x_nxt = SUM_W'(vertex_x) + SUM_W'(off_x);
    sum_y_nxt = SUM_W'(vertex_y) + SUM_W'(off_y);
  end

  assign prod_x_nxt = sum_x_r * $signed({1'b0, len_r});
  assign prod_y_nxt = sum_y_r * $signed({1'b0, len_r});

  always_comb begin
    rnd_x   = round_pix(prod_x_r);
    rnd_y   = round_pix(prod_y_r);
    inb_nxt = !rnd_x[PIX_W] && (rnd_x[PIX_W-1:0] < PIX_W'(w2_r)) &&
              !rnd_y[PIX_W] && (rnd_y[PIX_W-1:0] < PIX_W'(h2_r));
  end

  assign idx_nxt = IDX_W'(col3_r) * IDX_W'(h3_r) + IDX_W'(row3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_x_r   <= sum_x_nxt;
    sum_y_r   <= sum_y_nxt;
    len_r     <= len_c;
    w1_r      <= w_c;
    h1_r      <= h_c;
    depth1_r  <= vertex_depth;

    prod_x_r  <= prod_x_nxt;
    prod_y_r  <= prod_y_nxt;
    w2_r      <= w1_r;
    h2_r      <= h1_r;
    depth2_r  <= depth1_r;

    inb3_r    <= inb_nxt;
    col3_r    <= rnd_x[SIDE_W-1:0];
    row3_r    <= rnd_y[SIDE_W-1:0];
    h3_r      <= h2_r;
    depth3_r  <= depth2_r;

    inb4_r    <= inb3_r;
    col4_r    <= col3_r;
    row4_r    <= row3_r;
    idx_r     <= idx_nxt;
    depth4_r  <= depth3_r;
  end

  assign req       = '{valid: s4_valid_r, inb: inb4_r, col: col4_r, row: row4_r};
  assign req_addr  = idx_r;
  assign req_depth = depth4_r;

endmodule

// ===== hw/rtl/pzb_depth_store.sv =====
// depth memory with clear sweep and read-compare-write of one vertex
module pzb_depth_store #(
  parameter int DEPTH_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              sweep_en,
  input  pzb_pkg::pix_req_t                 req,
  input  logic [pzb_pkg::IDX_W-1:0]         req_addr,
  input  logic signed [DEPTH_BITS-1:0]      req_depth,
  output pzb_pkg::store_stat_t              stat,
  output logic                              out_hit,
  output logic [pzb_pkg::SIDE_W-1:0]        out_col,
  output logic [pzb_pkg::SIDE_W-1:0]        out_row,
  output logic signed [DEPTH_BITS-1:0]      out_depth
);
  import pzb_pkg::*;

  localparam int ENTRIES = MAX_SIDE * MAX_SIDE;
  localparam int AW      = $clog2(ENTRIES);
  localparam int WORD_W  = DEPTH_BITS + 1;

  logic [WORD_W-1:0] mem [ENTRIES];

  logic [AW-1:0]     sweep_cnt_r, sweep_cnt_nxt;
  logic              sweep_last;

  logic [WORD_W-1:0] rd_word_r;
  logic              a_valid_r, a_inb_r;
  logic [SIDE_W-1:0] a_col_r, a_row_r;
  logic [AW-1:0]     a_addr_r;
  logic signed [DEPTH_BITS-1:0] a_depth_r;

  logic                         stored_ok;
  logic signed [DEPTH_BITS-1:0] stored_depth;
  logic                         wins;
  logic                         we;
  logic [AW-1:0]                wr_addr;
  logic [WORD_W-1:0]            wr_word;

  logic                         strobe_r, hit_r;
  logic [SIDE_W-1:0]            col_r, row_r;
  logic signed [DEPTH_BITS-1:0] depth_r;

  assign sweep_last    = (sweep_cnt_r == AW'(ENTRIES - 1));
  assign sweep_cnt_nxt = sweep_last ? '0 : sweep_cnt_r + AW'(1);

  always_comb begin
    stored_ok    = rd_word_r[DEPTH_BITS];
    stored_depth = rd_word_r[DEPTH_BITS-1:0];
    wins         = a_inb_r && (!stored_ok || (stored_depth > a_depth_r));
    we           = sweep_en || (a_valid_r && wins);
    wr_addr      = sweep_en ? sweep_cnt_r : a_addr_r;
    wr_word      = sweep_en ? '0 : {1'b1, a_depth_r};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      rd_word_r <= mem[AW'(req_addr)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
      a_valid_r   <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      if (sweep_en) begin
        sweep_cnt_r <= sweep_cnt_nxt;
      end
      a_valid_r <= req.valid;
      strobe_r  <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_inb_r   <= req.inb;
    a_col_r   <= req.col;
    a_row_r   <= req.row;
    a_addr_r  <= AW'(req_addr);
    a_depth_r <= req_depth;
    hit_r     <= wins;
    col_r     <= wins ? a_col_r + SIDE_W'(1) : '0;
    row_r     <= wins ? a_row_r + SIDE_W'(1) : '0;
    depth_r   <= wins ? a_depth_r : '0;
  end

  assign stat      = '{sweep_last: sweep_last, done: strobe_r};
  assign out_hit   = hit_r;
  assign out_col   = col_r;
  assign out_row   = row_r;
  assign out_depth = depth_r;

endmodule

// ===== hw/rtl/point_zbuffer_projector_top.sv =====
// top level of the point z-buffer projector: registers, sequencer, datapath
//
//   channel  | handshake              | word
//   ---------+------------------------+------------------------------------------
//   input    | start && !busy         | in_command, in_vertex_x/_y, in_vertex_depth
//   result   | out_strobe, one cycle  | out_hit, out_pixel_column/_row, out_written_depth
//   config   | cfg_we                 | cfg_index, cfg_data
//
// a project word passes the mapping pipeline and the memory read before out_strobe;
// busy covers the mapping pipeline and the depth memory read and write-back.
// a clear word sweeps all MAX_SIDE*MAX_SIDE entries (65536 at the default) of the
// depth memory one entry a cycle; the same sweep runs after reset.
// results cannot be held off; one word is in flight at a time.
module point_zbuffer_projector_top #(
  parameter int DEPTH_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_command,
  input  logic signed [pzb_pkg::COORD_W-1:0]   in_vertex_x,
  input  logic signed [pzb_pkg::COORD_W-1:0]   in_vertex_y,
  input  logic signed [DEPTH_BITS-1:0]         in_vertex_depth,
  output logic                                 out_strobe,
  output logic                                 out_hit,
  output logic [pzb_pkg::SIDE_W-1:0]           out_pixel_column,
  output logic [pzb_pkg::SIDE_W-1:0]           out_pixel_row,
  output logic signed [DEPTH_BITS-1:0]         out_written_depth,
  input  logic                                 cfg_we,
  input  logic [pzb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pzb_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pzb_pkg::*;

  logic [SIDE_W-1:0]   width_r, height_r;
  logic [ASPECT_W-1:0] aspect_r;

  state_t              state_r, state_nxt;
  logic                sweep_en;
  logic                proj_go;

  pix_req_t                     req;
  logic [IDX_W-1:0]             req_addr;
  logic signed [DEPTH_BITS-1:0] req_depth;
  store_stat_t                  stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      aspect_r <= ASPECT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   width_r  <= cfg_data[SIDE_W-1:0];
        CFG_IMAGE_HEIGHT:  height_r <= cfg_data[SIDE_W-1:0];
        CFG_ASPECT_OFFSET: aspect_r <= cfg_data[ASPECT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sweep_en  = 1'b0;
    proj_go   = 1'b0;
    case (state_r)
      ST_SWEEP: begin
        sweep_en = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_command == CMD_CLEAR) begin
            state_nxt = ST_SWEEP;
          end else begin
            proj_go   = 1'b1;
            state_nxt = ST_BUSY;
          end
        end
      end
      ST_BUSY: begin
        if (stat.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_SWEEP;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  pzb_project #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_project (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (proj_go),
    .vertex_x     (in_vertex_x),
    .vertex_y     (in_vertex_y),
    .vertex_depth (in_vertex_depth),
    .cfg_width    (width_r),
    .cfg_height   (height_r),
    .cfg_aspect   (aspect_r),
    .req          (req),
    .req_addr     (req_addr),
    .req_depth    (req_depth)
  );

  pzb_depth_store #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .sweep_en  (sweep_en),
    .req       (req),
    .req_addr  (req_addr),
    .req_depth (req_depth),
    .stat      (stat),
    .out_hit   (out_hit),
    .out_col   (out_pixel_column),
    .out_row   (out_pixel_row),
    .out_depth (out_written_depth)
  );

  assign out_strobe = stat.done;

endmodule

// ===== hw/rtl/pzb_checker.sv =====
// port-level checks for the point z-buffer projector, bound to the top level
`include "point_zbuffer_projector_top_defines.svh"

module pzb_checker #(
  parameter int DEPTH_BITS = 24
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_strobe,
  input logic                              out_hit,
  input logic [pzb_pkg::SIDE_W-1:0]        out_pixel_column,
  input logic [pzb_pkg::SIDE_W-1:0]        out_pixel_row,
  input logic signed [DEPTH_BITS-1:0]      out_written_depth
);

  `PZB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `PZB_ASSERT_NOW(a_strobe_in_busy, out_strobe, busy)
  `PZB_ASSERT_NEXT(a_strobe_then_idle, out_strobe, !out_strobe && !busy)
  `PZB_ASSERT_NOW(a_miss_zero, out_strobe && !out_hit, out_pixel_column == '0 && out_pixel_row == '0 && out_written_depth == '0)
  `PZB_ASSERT_NOW(a_hit_coords, out_strobe && out_hit, out_pixel_column != '0 && out_pixel_row != '0)

endmodule

bind point_zbuffer_projector_top pzb_checker #(.DEPTH_BITS(DEPTH_BITS)) u_pzb_checker (.*);
